@@ sv/mwuf_pkg.sv @@
// Shared types, codes and microcode table for the maze wall union-find block.
package mwuf_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W   = 5;
  localparam int unsigned DIM_W     = 6;
  localparam int unsigned OUTC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned COND_W    = 3;
  // Enough for x * height + y at 6-bit operands
  localparam int unsigned PROD_W    = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUT_REMOVED = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_KEPT    = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_BORDER  = 2'd2;

  // Microprogram step addresses
  localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WALK_A = 3'd3;
  localparam logic [STEP_W-1:0] STEP_WALK_B = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;

  // Jump condition codes
  localparam logic [COND_W-1:0] COND_NONE     = 3'd0;
  localparam logic [COND_W-1:0] COND_NO_BEAT  = 3'd1;
  localparam logic [COND_W-1:0] COND_BORDER   = 3'd2;
  localparam logic [COND_W-1:0] COND_LINK     = 3'd3;
  localparam logic [COND_W-1:0] COND_BUSY     = 3'd4;
  localparam logic [COND_W-1:0] COND_CLR_MORE = 3'd5;

  // Datapath controls, one bit per micro-operation
  typedef struct packed {
    logic clr;      // write one entry of the clearing pass
    logic take_in;  // open the input channel
    logic start_a;  // latch cell indexes, start walk at first cell
    logic walk;     // follow the parent link just read
    logic fin_a;    // at a root: keep it, start walk at second cell
    logic fin_b;    // at a root: merge or keep
    logic emit;     // load the result register
  } ctrl_t;

  // Status flags seen by the sequencer
  typedef struct packed {
    logic no_beat;
    logic border;
    logic link;
    logic busy;
    logic clr_more;
  } flags_t;

  // One control word
  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] tgt;
    logic [STEP_W-1:0] nxt;
    ctrl_t             ctrl;
  } uword_t;

  // Microprogram ROM: branch to tgt when cond holds, else go to nxt
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w      = '0;
    w.cond = COND_NONE;
    w.tgt  = STEP_IDLE;
    w.nxt  = STEP_IDLE;
    unique case (step)
      STEP_CLEAR: begin
        w.ctrl.clr = 1'b1;
        w.cond     = COND_CLR_MORE;
        w.tgt      = STEP_CLEAR;
        w.nxt      = STEP_IDLE;
      end
      STEP_IDLE: begin
        w.ctrl.take_in = 1'b1;
        w.cond         = COND_NO_BEAT;
        w.tgt          = STEP_IDLE;
        w.nxt          = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.ctrl.start_a = 1'b1;
        w.cond         = COND_BORDER;
        w.tgt          = STEP_EMIT;
        w.nxt          = STEP_WALK_A;
      end
      STEP_WALK_A: begin
        w.ctrl.walk  = 1'b1;
        w.ctrl.fin_a = 1'b1;
        w.cond       = COND_LINK;
        w.tgt        = STEP_WALK_A;
        w.nxt        = STEP_WALK_B;
      end
      STEP_WALK_B: begin
        w.ctrl.walk  = 1'b1;
        w.ctrl.fin_b = 1'b1;
        w.cond       = COND_LINK;
        w.tgt        = STEP_WALK_B;
        w.nxt        = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_BUSY;
        w.tgt       = STEP_EMIT;
        w.nxt       = STEP_IDLE;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Register write clamp: zero reads as one, above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > int'(hi)) begin
      r = DIM_W'(hi);
    end
    return r;
  endfunction

endpackage

@@ sv/mwuf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mwuf_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mwuf_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module mwuf_seq
  import mwuf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  uword_t            uw;
  logic              jump;

  assign uw     = ucode_rom(pc_q);
  assign ctrl_o = uw.ctrl;

  // Branch condition select
  always_comb begin
    unique case (uw.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_BEAT:  jump = flags_i.no_beat;
      COND_BORDER:   jump = flags_i.border;
      COND_LINK:     jump = flags_i.link;
      COND_BUSY:     jump = flags_i.busy;
      COND_CLR_MORE: jump = flags_i.clr_more;
      default:       jump = 1'b0;
    endcase
  end

  assign pc_d = jump ? uw.tgt : uw.nxt;

  // Step counter; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/maze_wall_union_find.sv @@
// Top level: config registers, union-find datapath, parent memory, sequencer.
//
//  channel  dir  handshake                 payload
//  input    in   in_valid_i / in_stall_o   cell_x_i, cell_y_i, direction_i
//  result   out  out_valid_o / out_stall_i outcome_o
//  config   in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A border wall goes from the check step straight to the emit step; any other
// item walks the parent links from each cell to its root; each link costs one
// read of the parent memory, whose read port sets the pace.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (1024 by default)
// points every cell at itself; in_stall_o stays high during it.
// The result register lets the next item enter while a result waits; the
// sequencer holds in its emit step only if the previous result is still stalled.
module maze_wall_union_find
  import mwuf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned MAX_HEIGHT = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic                 direction_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUTC_W-1:0]    outcome_o,
  // config writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int unsigned CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned SUM_W      = (IDX_W > PROD_W) ? IDX_W : PROD_W;
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(CELL_COUNT - 1);

  ctrl_t  ctrl;
  flags_t flags;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic               dir_q;
  logic [IDX_W-1:0]   node_q, cell_b_q, root_q, clr_q;
  logic [OUTC_W-1:0]  res_q;
  logic               out_valid_q;
  logic [OUTC_W-1:0]  out_outcome_q;

  logic               in_beat, out_busy, link, border;
  logic [DIM_W:0]     x_ext, y_ext, w_ext, h_ext;
  logic [DIM_W-1:0]   x2, y2;
  logic [SUM_W-1:0]   a_sum, b_sum;
  logic [IDX_W-1:0]   cell_a, cell_b;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_wdata, mem_raddr, mem_rdata;

  // Config port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_dim(DIM_W'(32), MAX_WIDTH);
      height_q <= clamp_dim(DIM_W'(32), MAX_HEIGHT);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:  width_q  <= clamp_dim(cfg_data_i, MAX_WIDTH);
        REG_GRID_HEIGHT: height_q <= clamp_dim(cfg_data_i, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_stall_o  = !ctrl.take_in;
  assign in_beat     = in_valid_i && ctrl.take_in;
  assign out_busy    = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign outcome_o   = out_outcome_q;

  // Input operands
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q   <= cell_x_i;
      y_q   <= cell_y_i;
      dir_q <= direction_i;
    end
  end

  // Border and range check
  assign x_ext = (DIM_W+1)'(x_q);
  assign y_ext = (DIM_W+1)'(y_q);
  assign w_ext = (DIM_W+1)'(width_q);
  assign h_ext = (DIM_W+1)'(height_q);

  always_comb begin
    border = (x_ext >= w_ext) || (y_ext >= h_ext);
    if (!dir_q) begin
      border = border || ((y_ext + (DIM_W+1)'(1)) >= h_ext);
    end else begin
      border = border || ((x_ext + (DIM_W+1)'(1)) >= w_ext);
    end
  end

  // Cell indexes: x * height + y
  assign x2     = DIM_W'(x_q) + DIM_W'(dir_q);
  assign y2     = DIM_W'(y_q) + DIM_W'(!dir_q);
  assign a_sum  = SUM_W'(x_q) * SUM_W'(height_q) + SUM_W'(y_q);
  assign b_sum  = SUM_W'(x2) * SUM_W'(height_q) + SUM_W'(y2);
  assign cell_a = a_sum[IDX_W-1:0];
  assign cell_b = b_sum[IDX_W-1:0];

  // Parent link just read differs from the node: not yet at a root
  assign link = (mem_rdata != node_q);

  // Memory read address select
  always_comb begin
    mem_raddr = node_q;
    if (ctrl.start_a) begin
      mem_raddr = cell_a;
    end else if (ctrl.walk && link) begin
      mem_raddr = mem_rdata;
    end else if (ctrl.fin_a) begin
      mem_raddr = cell_b_q;
    end
  end

  // Memory write: clearing pass or root merge
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = root_q;
    if (ctrl.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = clr_q;
    end else if (ctrl.fin_b && !link && (node_q != root_q)) begin
      mem_we = 1'b1;
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    if (ctrl.start_a) begin
      node_q   <= cell_a;
      cell_b_q <= cell_b;
      res_q    <= OUT_BORDER;
    end else if (ctrl.walk && link) begin
      node_q <= mem_rdata;
    end else if (ctrl.fin_a) begin
      root_q <= node_q;
      node_q <= cell_b_q;
    end else if (ctrl.fin_b) begin
      res_q <= (node_q == root_q) ? OUT_KEPT : OUT_REMOVED;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl.clr && (clr_q != CLR_LAST)) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && !out_busy) begin
      out_outcome_q <= res_q;
    end
  end

  // Sequencer flags
  assign flags.no_beat  = !in_valid_i;
  assign flags.border   = border;
  assign flags.link     = link;
  assign flags.busy     = out_busy;
  assign flags.clr_more = (clr_q != CLR_LAST);

  mwuf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  mwuf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CELL_COUNT)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // An accepted beat moves the sequencer out of its input step
  a_beat_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !ctrl.take_in)
    else $error("input stayed open after a beat");

  // A result appears only from the emit step
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.emit))
    else $error("result loaded outside emit step");

  // A merge never writes a self link
  a_merge_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !ctrl.clr) |-> (mem_wdata != mem_waddr))
    else $error("merge wrote a self link");

  // No item enters during the clearing pass
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clr |-> in_stall_o)
    else $error("input open during clearing pass");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the maze wall union-find block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mwuf_pkg::*;

  localparam int unsigned DIM_MAX    = 32;
  localparam int unsigned CELLS      = DIM_MAX * DIM_MAX;
  localparam int unsigned IDLE_LIMIT = 30000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_WAIT = 20;

  // Shadow forest of parent links and the queue of outcomes still owed
  class carve_board;
    typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               dir;
      logic [OUTC_W-1:0]  outcome;
    } wall_t;

    logic [9:0]  parent [CELLS];
    int unsigned width;
    int unsigned height;
    wall_t       outcome_q [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      for (int i = 0; i < CELLS; i++) parent[i] = 10'(i);
      width   = DIM_MAX;
      height  = DIM_MAX;
      errors  = 0;
      checked = 0;
    endfunction

    // Register write; zero reads as one, oversize as the maximum
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      int unsigned v;
      v = data;
      if (v == 0) v = 1;
      else if (v > DIM_MAX) v = DIM_MAX;
      if (idx == REG_GRID_WIDTH) width = v;
      else if (idx == REG_GRID_HEIGHT) height = v;
    endfunction

    // Follow links up to the set root, no compression
    function int unsigned root_of(int unsigned node);
      int unsigned steps;
      steps = 0;
      while (steps < CELLS && parent[node] != node) begin
        node = parent[node];
        steps++;
      end
      return node;
    endfunction

    // Carve one wall in the shadow forest and queue its outcome
    function void note_wall(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic dir);
      wall_t       w;
      int unsigned x2, y2, ra, rb;
      w.x = x;
      w.y = y;
      w.dir = dir;
      x2 = x;
      y2 = y;
      if (x >= width || y >= height) begin
        w.outcome = OUT_BORDER;
      end else if (dir == 1'b0 && y + 1 >= height) begin
        w.outcome = OUT_BORDER;
      end else if (dir == 1'b1 && x + 1 >= width) begin
        w.outcome = OUT_BORDER;
      end else begin
        if (dir == 1'b0) y2 = y + 1;
        else x2 = x + 1;
        ra = root_of(x * height + y);
        rb = root_of(x2 * height + y2);
        if (ra != rb) begin
          parent[rb] = 10'(ra);
          w.outcome = OUT_REMOVED;
        end else begin
          w.outcome = OUT_KEPT;
        end
      end
      outcome_q.push_back(w);
    endfunction

    // Compare one result beat with the oldest owed outcome
    function void check_outcome(logic [OUTC_W-1:0] actual);
      wall_t w;
      checked++;
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, outcome %0d", $time, actual);
      end else begin
        w = outcome_q.pop_front();
        if (actual !== w.outcome) begin
          errors++;
          $display("%0t: outcome mismatch for x=%0d y=%0d dir=%0d: expected %0d, actual %0d",
                   $time, w.x, w.y, w.dir, w.outcome, actual);
        end
      end
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall_o;
  logic [COORD_W-1:0]   cell_x;
  logic [COORD_W-1:0]   cell_y;
  logic                 direction;
  logic                 out_valid_o;
  logic                 out_stall;
  logic [OUTC_W-1:0]    outcome_o;
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  carve_board board;
  bit         pressure_done;

  maze_wall_union_find u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .cell_x_i    (cell_x),
    .cell_y_i    (cell_y),
    .direction_i (direction),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .outcome_o   (outcome_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Result beats are checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) board.check_outcome(outcome_o);
  end

  // One input beat: hold the payload until the block takes it
  task automatic send_wall(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic dir);
    @(negedge clk_i);
    in_valid  <= 1'b1;
    cell_x    <= x;
    cell_y    <= y;
    direction <= dir;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_wall(x, y, dir);
  endtask

  task automatic idle_input(int unsigned cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly walls inside the grid, some at its edges, some pure noise
  task automatic pick_wall(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y,
                           output logic dir);
    int unsigned r;
    int unsigned ex [4];
    int unsigned ey [4];
    r = $urandom_range(0, 99);
    ex = '{0, board.width - 1, board.width % DIM_MAX, DIM_MAX - 1};
    ey = '{0, board.height - 1, board.height % DIM_MAX, DIM_MAX - 1};
    if (r < 80) begin
      x = COORD_W'($urandom_range(0, board.width - 1));
      y = COORD_W'($urandom_range(0, board.height - 1));
    end else if (r < 92) begin
      x = COORD_W'(ex[$urandom_range(0, 3)]);
      y = COORD_W'(ey[$urandom_range(0, 3)]);
    end else begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end
    dir = 1'($urandom_range(0, 1));
  endtask

  // Random walls in bursts, mostly separated by random gaps
  task automatic carve_random(int unsigned count);
    logic [COORD_W-1:0] x, y;
    logic               dir;
    int unsigned        sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        pick_wall(x, y, dir);
        send_wall(x, y, dir);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
    end
    idle_input(1);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int unsigned mode, span;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk_i);
        if (!pressure_done && board.checked >= 120) begin
          pressure_done = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_LEN) @(negedge clk_i);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Watchdog: cycles with no beat on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned phase_w [7];
    int unsigned phase_h [7];
    int unsigned phase_n [7];
    board         = new();
    pressure_done = 1'b0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    cell_x    <= '0;
    cell_y    <= '0;
    direction <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walls on the full 32 by 32 grid
    send_wall(5'd0, 5'd0, 1'b0);
    send_wall(5'd0, 5'd0, 1'b1);
    send_wall(5'd0, 5'd1, 1'b1);
    send_wall(5'd1, 5'd0, 1'b0);
    send_wall(5'd0, 5'd0, 1'b0);
    send_wall(5'd31, 5'd31, 1'b0);
    send_wall(5'd31, 5'd31, 1'b1);
    send_wall(5'd31, 5'd0, 1'b1);
    send_wall(5'd0, 5'd31, 1'b0);
    send_wall(5'd30, 5'd31, 1'b1);
    send_wall(5'd31, 5'd30, 1'b0);
    send_wall(5'd30, 5'd30, 1'b0);
    send_wall(5'd30, 5'd30, 1'b1);
    idle_input(1);
    wait_drained();

    // Grid settings per phase, raw register values incl. out-of-range ones
    phase_w = '{0, 2, 63, 5, 3, 17, 32};
    phase_h = '{0, 63, 1, 7, 20, 9, 32};
    phase_n = '{40, 150, 150, 200, 200, 200, 700};
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_GRID_WIDTH, DIM_W'(phase_w[p]));
      write_reg(REG_GRID_HEIGHT, DIM_W'(phase_h[p]));
      carve_random(phase_n[p]);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
